// ===== hdl/sequence_ordered_reorder_buffer_assert.svh =====
// Assertion macros for the sequence-ordered reorder buffer checker
`ifndef SEQUENCE_ORDERED_REORDER_BUFFER_ASSERT_SVH
`define SEQUENCE_ORDERED_REORDER_BUFFER_ASSERT_SVH

// same-cycle implication
`define SORB_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("reorder buffer assertion failed");

// next-cycle implication
`define SORB_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("reorder buffer assertion failed");

`endif

// ===== hdl/sorb_pkg.sv =====
// Shared types and constants for the sequence-ordered reorder buffer
`timescale 1ns / 1ps
package sorb_pkg;

  localparam int SEQ_W            = 32;
  localparam int PORT_HANDLE_W    = 32;
  localparam int SIZE_W           = 16;
  localparam int CNT_W            = 5;
  localparam int S_TDATA_W        = 80;
  localparam int M_TDATA_W        = 88;
  localparam int DEF_CAPACITY     = 16;
  localparam int DEF_HANDLE_WIDTH = 32;

  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_POP     = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic                     is_pop;
    logic [SEQ_W-1:0]         seq;
    logic [PORT_HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]        size;
  } item_t;

endpackage

// ===== hdl/sequence_ordered_reorder_buffer.sv =====
// Top level of the sequence-ordered reorder buffer
//
//  channel | signals                          | direction
//  s_      | tvalid tready tdata[79:0] tuser  | command in
//  m_      | tvalid tready tdata[87:0]        | result out
//
// Insert does one store read per step of the search and one read and write
// per moved entry; pop reads the head entry and, if others remain, the next.
// The store has one write and one read port, which sets this pacing.
// Reset clears the entry count and queue; store contents need no clearing.
// A result waits in the output register; the next command starts once it
// is transferred, while the input queue keeps taking up to two commands.
`timescale 1ns / 1ps
module sequence_ordered_reorder_buffer import sorb_pkg::*; #(
  parameter int CAPACITY     = DEF_CAPACITY,
  parameter int HANDLE_WIDTH = DEF_HANDLE_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // sequence_req[31:0], data_handle[63:32], data_size[79:64]
  input  logic [S_TDATA_W-1:0] s_tdata,
  // cmd
  input  logic                 s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // status[0], popped_handle[32:1], popped_size[48:33], first_sequence[80:49],
  // is_empty[81], entry_count[86:82], zero[87]
  output logic [M_TDATA_W-1:0] m_tdata
);

  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  sorb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_ready  (q_ready)
  );

  sorb_engine #(
    .CAPACITY     (CAPACITY),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_ready  (q_ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== hdl/sorb_front.sv =====
// Input queue: takes command transfers and classifies them for the engine
`timescale 1ns / 1ps
module sorb_front import sorb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 s_tuser,
  output logic                 q_valid,
  output item_t                q_item,
  input  logic                 q_ready
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       push;
  logic       pull;
  item_t      in_item;

  always_comb begin
    in_item.is_pop = (s_tuser == CMD_POP);
    in_item.seq    = s_tdata[31:0];
    in_item.handle = s_tdata[63:32];
    in_item.size   = s_tdata[79:64];
  end

  assign s_tready = (cnt != 2'd2);
  assign q_valid  = (cnt != 2'd0);
  assign q_item   = slots[rd_ptr];
  assign push     = s_tvalid && s_tready;
  assign pull     = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pull) rd_ptr <= ~rd_ptr;
      cnt <= cnt + {1'b0, push} - {1'b0, pull};
    end
    if (push) slots[wr_ptr] <= in_item;
  end

endmodule

// ===== hdl/sorb_engine.sv =====
// Sorted store and its sequencer: search, shift, replace and pop
`timescale 1ns / 1ps
module sorb_engine import sorb_pkg::*; #(
  parameter int CAPACITY     = DEF_CAPACITY,
  parameter int HANDLE_WIDTH = DEF_HANDLE_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  item_t                q_item,
  output logic                 q_ready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OW = $clog2(CAPACITY + 1);
  localparam int HW = HANDLE_WIDTH;

  typedef enum logic [2:0] {
    IDLE, SEARCH, PLACE, SHIFT, WRITE, POP_HEAD, POP_NEXT
  } state_t;

  function automatic logic [IW-1:0] to_phys(input logic [IW-1:0] h, input logic [OW-1:0] l);
    logic [OW:0] s;
    s = (OW+1)'(h) + (OW+1)'(l);
    if (s >= (OW+1)'(CAPACITY)) s = s - (OW+1)'(CAPACITY);
    return s[IW-1:0];
  endfunction

  function automatic logic [HW-1:0] to_store(input logic [PORT_HANDLE_W-1:0] v);
    logic [HW+PORT_HANDLE_W-1:0] t;
    t = {{HW{1'b0}}, v};
    return t[HW-1:0];
  endfunction

  function automatic logic [PORT_HANDLE_W-1:0] to_port(input logic [HW-1:0] v);
    logic [HW+PORT_HANDLE_W-1:0] t;
    t = {{PORT_HANDLE_W{1'b0}}, v};
    return t[PORT_HANDLE_W-1:0];
  endfunction

  logic [SEQ_W-1:0]  key_mem    [CAPACITY];
  logic [HW-1:0]     handle_mem [CAPACITY];
  logic [SIZE_W-1:0] size_mem   [CAPACITY];
  logic [SEQ_W-1:0]  rd_key;
  logic [HW-1:0]     rd_handle;
  logic [SIZE_W-1:0] rd_size;

  state_t            state, state_next;
  logic [IW-1:0]     head, head_next;
  logic [OW-1:0]     occ, occ_next;
  logic [OW-1:0]     pos, pos_next;
  logic [OW-1:0]     j, j_next;
  logic [SEQ_W-1:0]  first_key, first_next;
  logic [HW-1:0]     ph, ph_next;
  logic [SIZE_W-1:0] ps, ps_next;
  item_t             cur, cur_next;
  logic              out_valid;

  logic [OW-1:0]     rd_lidx;
  logic              wr_en;
  logic [OW-1:0]     wr_lidx;
  logic [SEQ_W-1:0]  wr_key;
  logic [HW-1:0]     wr_handle;
  logic [SIZE_W-1:0] wr_size;
  logic              emit;
  logic              e_status;
  logic [HW-1:0]     e_handle;
  logic [SIZE_W-1:0] e_size;
  logic [OW+CNT_W-1:0] cnt_ext;

  logic                     o_status;
  logic [PORT_HANDLE_W-1:0] o_handle;
  logic [SIZE_W-1:0]        o_size;
  logic [SEQ_W-1:0]         o_first;
  logic                     o_empty;
  logic [CNT_W-1:0]         o_count;

  always_comb begin
    state_next = state;
    head_next  = head;
    occ_next   = occ;
    pos_next   = pos;
    j_next     = j;
    first_next = first_key;
    ph_next    = ph;
    ps_next    = ps;
    cur_next   = cur;
    q_ready    = 1'b0;
    rd_lidx    = '0;
    wr_en      = 1'b0;
    wr_lidx    = pos;
    wr_key     = cur.seq;
    wr_handle  = to_store(cur.handle);
    wr_size    = cur.size;
    emit       = 1'b0;
    e_status   = STATUS_OK;
    e_handle   = '0;
    e_size     = '0;
    unique case (state)
      IDLE: begin
        q_ready = !out_valid;
        if (q_valid && !out_valid) begin
          cur_next = q_item;
          if (q_item.is_pop) begin
            if (occ == '0) emit = 1'b1;
            else state_next = POP_HEAD;
          end else if (occ == '0) begin
            wr_en      = 1'b1;
            wr_lidx    = '0;
            wr_key     = q_item.seq;
            wr_handle  = to_store(q_item.handle);
            wr_size    = q_item.size;
            occ_next   = OW'(1);
            first_next = q_item.seq;
            emit       = 1'b1;
          end else begin
            pos_next   = '0;
            state_next = SEARCH;
          end
        end
      end
      SEARCH: begin
        if (rd_key == cur.seq) begin
          wr_en      = 1'b1;
          emit       = 1'b1;
          state_next = IDLE;
        end else if (rd_key > cur.seq) begin
          state_next = PLACE;
        end else if (pos + OW'(1) == occ) begin
          pos_next   = occ;
          state_next = PLACE;
        end else begin
          pos_next = pos + OW'(1);
          rd_lidx  = pos + OW'(1);
        end
      end
      PLACE: begin
        if (occ == OW'(CAPACITY)) begin
          e_status   = STATUS_FULL;
          emit       = 1'b1;
          state_next = IDLE;
        end else if (pos == occ) begin
          wr_en    = 1'b1;
          occ_next = occ + OW'(1);
          if (pos == '0) first_next = cur.seq;
          emit       = 1'b1;
          state_next = IDLE;
        end else begin
          rd_lidx    = occ - OW'(1);
          j_next     = occ;
          state_next = SHIFT;
        end
      end
      SHIFT: begin
        wr_en     = 1'b1;
        wr_lidx   = j;
        wr_key    = rd_key;
        wr_handle = rd_handle;
        wr_size   = rd_size;
        if (j - OW'(1) == pos) begin
          state_next = WRITE;
        end else begin
          rd_lidx = j - OW'(2);
          j_next  = j - OW'(1);
        end
      end
      WRITE: begin
        wr_en    = 1'b1;
        occ_next = occ + OW'(1);
        if (pos == '0) first_next = cur.seq;
        emit       = 1'b1;
        state_next = IDLE;
      end
      POP_HEAD: begin
        ph_next = rd_handle;
        ps_next = rd_size;
        if (occ == OW'(1)) begin
          occ_next   = '0;
          e_handle   = rd_handle;
          e_size     = rd_size;
          emit       = 1'b1;
          state_next = IDLE;
        end else begin
          rd_lidx    = OW'(1);
          state_next = POP_NEXT;
        end
      end
      POP_NEXT: begin
        first_next = rd_key;
        head_next  = to_phys(head, OW'(1));
        occ_next   = occ - OW'(1);
        e_handle   = ph;
        e_size     = ps;
        emit       = 1'b1;
        state_next = IDLE;
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[to_phys(head, wr_lidx)]    <= wr_key;
      handle_mem[to_phys(head, wr_lidx)] <= wr_handle;
      size_mem[to_phys(head, wr_lidx)]   <= wr_size;
    end
    rd_key    <= key_mem[to_phys(head, rd_lidx)];
    rd_handle <= handle_mem[to_phys(head, rd_lidx)];
    rd_size   <= size_mem[to_phys(head, rd_lidx)];
  end

  assign cnt_ext = {{CNT_W{1'b0}}, occ_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      head      <= '0;
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      occ   <= occ_next;
      if (emit) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
    pos       <= pos_next;
    j         <= j_next;
    first_key <= first_next;
    ph        <= ph_next;
    ps        <= ps_next;
    cur       <= cur_next;
    if (emit) begin
      o_status <= e_status;
      o_handle <= to_port(e_handle);
      o_size   <= e_size;
      o_first  <= (occ_next == '0) ? '0 : first_next;
      o_empty  <= (occ_next == '0);
      o_count  <= cnt_ext[CNT_W-1:0];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, o_count, o_empty, o_first, o_size, o_handle, o_status};

endmodule

// ===== hdl/sorb_checker.sv =====
// Port-level checker for the sequence-ordered reorder buffer, with its bind
`timescale 1ns / 1ps
`include "sequence_ordered_reorder_buffer_assert.svh"
module sorb_checker import sorb_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata
);

  `SORB_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready,
                    m_tvalid && $stable(m_tdata))
  `SORB_ASSERT_NOW(a_empty_zero, clk, rst, m_tvalid && m_tdata[81],
                   m_tdata[86:82] == 5'd0 && m_tdata[80:49] == 32'd0)
  `SORB_ASSERT_NOW(a_full_no_pop, clk, rst, m_tvalid && m_tdata[0] == STATUS_FULL,
                   m_tdata[48:1] == 48'd0 && !m_tdata[81])
  `SORB_ASSERT_NOW(a_pad_zero, clk, rst, m_tvalid, !m_tdata[87])

endmodule

bind sequence_ordered_reorder_buffer sorb_checker u_sorb_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== sim/sorb_checker.sv =====
// Checker for the reorder buffer: predicts each result and compares it
`timescale 1ns / 1ps
module sorb_scoreboard import sorb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 s_tuser,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [M_TDATA_W-1:0] m_tdata,
  output int                   fail_count,
  output int                   pending
);

  typedef struct packed {
    logic                     status;
    logic [PORT_HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]        size;
    logic [SEQ_W-1:0]         first_seq;
    logic                     empty;
    logic [CNT_W-1:0]         count;
  } outcome_t;

  localparam int DEPTH = DEF_CAPACITY;

  logic [SEQ_W-1:0]         keys    [DEPTH];
  logic [PORT_HANDLE_W-1:0] handles [DEPTH];
  logic [SIZE_W-1:0]        sizes   [DEPTH];
  int                       fill;
  outcome_t                 awaited [$];

  assign pending = awaited.size();

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic outcome_t apply_command(input logic pop, input logic [SEQ_W-1:0] seq,
                                              input logic [PORT_HANDLE_W-1:0] hnd,
                                              input logic [SIZE_W-1:0] sz);
    outcome_t r;
    int pos;
    r = '0;
    if (pop == CMD_POP) begin
      if (fill > 0) begin
        r.handle = handles[0];
        r.size   = sizes[0];
        for (int i = 1; i < fill; i++) begin
          keys[i-1] = keys[i]; handles[i-1] = handles[i]; sizes[i-1] = sizes[i];
        end
        fill--;
      end
    end else begin
      pos = 0;
      while (pos < fill && keys[pos] < seq) pos++;
      if (pos < fill && keys[pos] == seq) begin
        handles[pos] = hnd; sizes[pos] = sz;
      end else if (fill >= DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        for (int i = fill; i > pos; i--) begin
          keys[i] = keys[i-1]; handles[i] = handles[i-1]; sizes[i] = sizes[i-1];
        end
        keys[pos] = seq; handles[pos] = hnd; sizes[pos] = sz;
        fill++;
      end
    end
    r.first_seq = fill > 0 ? keys[0] : '0;
    r.empty     = fill == 0;
    r.count     = fill[CNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    outcome_t w;
    if (rst) begin
      fill = 0;
      fail_count = 0;
      awaited.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (awaited.size() == 0) begin
          report("unexpected transfer", m_tdata[63:0], 0);
        end else begin
          w = awaited.pop_front();
          if (m_tdata[0] !== w.status) report("status", m_tdata[0], w.status);
          if (m_tdata[32:1] !== w.handle) report("popped_handle", m_tdata[32:1], w.handle);
          if (m_tdata[48:33] !== w.size) report("popped_size", m_tdata[48:33], w.size);
          if (m_tdata[80:49] !== w.first_seq)
            report("first_sequence", m_tdata[80:49], w.first_seq);
          if (m_tdata[81] !== w.empty) report("is_empty", m_tdata[81], w.empty);
          if (m_tdata[86:82] !== w.count) report("entry_count", m_tdata[86:82], w.count);
          if (m_tdata[87] !== 1'b0) report("pad bit", m_tdata[87], 0);
        end
      end
      if (s_tvalid && s_tready)
        awaited.push_back(apply_command(s_tuser, s_tdata[31:0], s_tdata[63:32],
                                        s_tdata[79:64]));
    end
  end

endmodule

// ===== sim/tb.sv =====
// Testbench top: drives commands into the reorder buffer and gives the verdict
`timescale 1ns / 1ps
module tb import sorb_pkg::*;;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;  // sequence_req, data_handle, data_size
  logic                 s_tuser;  // cmd
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;  // status, popped_handle, popped_size, first_sequence,
                                  // is_empty, entry_count, zero
  int                   fail_count;
  int                   pending;
  bit                   calm;

  sequence_ordered_reorder_buffer dut (.*);

  sorb_scoreboard checker_i (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // hold m_tready low in random bursts until the quiet tail
  initial begin
    m_tready = 0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      m_tready <= 1;
    end
  end

  task automatic send(input logic op, input logic [31:0] seq, input logic [31:0] hnd,
                      input logic [15:0] sz);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= op;
    s_tdata  <= {sz, hnd, seq};
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic logic [31:0] pick_seq(input int mode);
    case (mode)
      0: return 32'($urandom_range(0, 23));
      1: return 32'hFFFF_FFE8 + 32'($urandom_range(0, 23));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int mode;
    int pops;
    rst = 1; s_tvalid = 0; s_tuser = 0; s_tdata = '0; calm = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: empty pop, extremes, fill past capacity, replace when full, two pops
    send(CMD_POP, '1, '1, '1);
    send(CMD_INSERT, 32'd0, 32'hFFFF_FFFF, 16'hFFFF);
    send(CMD_INSERT, 32'hFFFF_FFFF, 32'd0, 16'd0);
    send(CMD_INSERT, 32'd0, 32'h1234_5678, 16'h00A5);
    for (int i = 0; i < 15; i++) send(CMD_INSERT, 32'h8000_0000 - 32'(i), $urandom, 16'($urandom));
    send(CMD_INSERT, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 16'h5A5A);
    send(CMD_POP, $urandom, $urandom, 16'($urandom));
    send(CMD_POP, $urandom, $urandom, 16'($urandom));
    // random: fill and drain phases with a mix of key ranges
    for (int n = 0; n < 500; n++) begin
      if (n >= 440) calm = 1;
      mode = $urandom_range(0, 2);
      pops = (n / 60) % 2 ? 60 : 30;
      if ($urandom_range(0, 99) < pops)
        send(CMD_POP, $urandom, $urandom, 16'($urandom));
      else
        send(CMD_INSERT, pick_seq(mode), $urandom, 16'($urandom));
    end
    s_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
